[rtl/core/imr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package imr_pkg;

  localparam logic [1:0] OP_ARM  = 2'd0;
  localparam logic [1:0] OP_BYTE = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [2:0] ST_ECHO     = 3'd0;
  localparam logic [2:0] ST_TEX      = 3'd1;
  localparam logic [2:0] ST_SHORT    = 3'd2;
  localparam logic [2:0] ST_OTHER    = 3'd3;
  localparam logic [2:0] ST_MISMATCH = 3'd4;
  localparam logic [2:0] ST_BADHDR   = 3'd5;

  localparam logic [1:0] REG_EXPECTED_ID = 2'd0;
  localparam logic [1:0] REG_ECHO_TYPE   = 2'd1;
  localparam logic [1:0] REG_TEX_TYPE    = 2'd2;
  localparam logic [1:0] REG_TARGET_IP   = 2'd3;

  localparam logic [7:0] TEX_TYPE_RESET = 8'd11;
  localparam int         HDR_MIN_BYTES  = 20;
  localparam int         ICMP_HDR_BYTES = 8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] seq;
    logic [7:0]  data;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic [15:0] expected_id;
    logic [7:0]  echo_type;
    logic [7:0]  tex_type;
    logic [31:0] target_ip;
  } cfg_t;

endpackage

`default_nettype wire

[rtl/core/icmp_response_matcher_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake             Payload
// in       in_valid / in_stall   op, probe_seq, data_byte, last_byte
// out      out_valid / out_stall status, matched, source_ip, rtt_ms, reached_target
// cfg      APB psel/penable      paddr, pwdata, prdata
//
// One item per cycle sustained while out_stall is low; after its last byte is accepted, a result
// passes through a queue slot, then the output register.
// A four-entry queue separates intake from the matcher; in_stall is queue full.
// While out_valid is high, out_stall holds the output register and stops the queue from draining.
// Synchronous rst clears the queue, the packet capture state and the config (tex_type resets to 11).

module icmp_response_matcher_core
  import imr_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  op,
  input  wire logic [15:0] probe_seq,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic             matched,
  output logic [31:0]      source_ip,
  output logic [15:0]      rtt_ms,
  output logic             reached_target,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t       cfg;
  cmd_t       push_cmd;
  cmd_t       head_cmd;
  logic       push, pop, full, not_empty;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_id <= '0;
      cfg.echo_type   <= '0;
      cfg.tex_type    <= TEX_TYPE_RESET;
      cfg.target_ip   <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_EXPECTED_ID: cfg.expected_id <= pwdata[15:0];
        REG_ECHO_TYPE:   cfg.echo_type   <= pwdata[7:0];
        REG_TEX_TYPE:    cfg.tex_type    <= pwdata[7:0];
        REG_TARGET_IP:   cfg.target_ip   <= pwdata;
        default:         cfg.target_ip   <= cfg.target_ip;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_EXPECTED_ID: prdata = {16'd0, cfg.expected_id};
      REG_ECHO_TYPE:   prdata = {24'd0, cfg.echo_type};
      REG_TEX_TYPE:    prdata = {24'd0, cfg.tex_type};
      REG_TARGET_IP:   prdata = cfg.target_ip;
      default:         prdata = '0;
    endcase
  end

  imr_front u_front (
    .in_valid  (in_valid),
    .full      (full),
    .op        (op),
    .probe_seq (probe_seq),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .in_stall  (in_stall),
    .push      (push),
    .cmd       (push_cmd)
  );

  imr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head_cmd  (head_cmd)
  );

  imr_back #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .not_empty      (not_empty),
    .head_cmd       (head_cmd),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .matched        (matched),
    .source_ip      (source_ip),
    .rtt_ms         (rtt_ms),
    .reached_target (reached_target)
  );

endmodule

`default_nettype wire

[rtl/core/imr_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module imr_front
  import imr_pkg::*;
(
  input  wire logic        in_valid,
  input  wire logic        full,
  input  wire logic [1:0]  op,
  input  wire logic [15:0] probe_seq,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             in_stall,
  output logic             push,
  output cmd_t             cmd
);

  logic known_op;

  assign in_stall = full;

  always_comb begin
    case (op)
      OP_ARM, OP_BYTE, OP_TICK: known_op = 1'b1;
      default:                  known_op = 1'b0;
    endcase
  end

  // unknown ops are taken and dropped here
  assign push     = in_valid && !full && known_op;
  assign cmd.kind = op;
  assign cmd.seq  = probe_seq;
  assign cmd.data = data_byte;
  assign cmd.last = last_byte && (op == OP_BYTE);

endmodule

`default_nettype wire

[rtl/core/imr_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module imr_queue
  import imr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output logic      full,
  output logic      not_empty,
  output cmd_t      head_cmd
);

  cmd_t                slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full      = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head_cmd  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/imr_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module imr_back
  import imr_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire logic        not_empty,
  input  wire cmd_t        head_cmd,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic             matched,
  output logic [31:0]      source_ip,
  output logic [15:0]      rtt_ms,
  output logic             reached_target
);

  localparam int PW = $clog2(MAX_PACKET_BYTES + 1);
  localparam int CW = PW + 1;

  logic [PW-1:0] byte_pos, byte_pos_next;
  logic [5:0]    outer_hdr_bytes, outer_hdr_bytes_next;
  logic [7:0]    icmp_kind, icmp_kind_next;
  logic [31:0]   src_addr, src_addr_next;
  logic [5:0]    inner_hdr_bytes, inner_hdr_bytes_next;
  logic [15:0]   seen_id, seen_id_next;
  logic [15:0]   seen_seq, seen_seq_next;
  logic [15:0]   want_seq;
  logic [15:0]   elapsed_ms;

  logic [CW-1:0] pos, hdr, inner_base, len, hdr_n, inner_n;
  logic [7:0]    b;
  logic          echo, tex, echo_n, tex_n, take, do_byte, do_report, hit;
  logic [2:0]    st;
  logic [31:0]   idseq;

  function automatic logic [31:0] capture(input logic [CW-1:0] pp, input logic [CW-1:0] base,
                                          input logic [7:0] bb, input logic [15:0] id,
                                          input logic [15:0] sq);
    logic [15:0] id_o;
    logic [15:0] sq_o;
    id_o = id;
    sq_o = sq;
    if (pp == base + CW'(4))      id_o = {bb, id[7:0]};
    else if (pp == base + CW'(5)) id_o = {id[15:8], bb};
    else if (pp == base + CW'(6)) sq_o = {bb, sq[7:0]};
    else if (pp == base + CW'(7)) sq_o = {sq[15:8], bb};
    return {id_o, sq_o};
  endfunction

  assign pop       = not_empty && (!out_valid || !out_stall);
  assign do_byte   = pop && (head_cmd.kind == OP_BYTE);
  assign do_report = do_byte && head_cmd.last;
  assign take      = do_byte && (byte_pos < PW'(MAX_PACKET_BYTES));
  assign b         = head_cmd.data;

  assign pos        = {1'b0, byte_pos};
  assign hdr        = CW'(outer_hdr_bytes);
  assign inner_base = hdr + CW'(ICMP_HDR_BYTES) + CW'(inner_hdr_bytes);
  assign echo       = (icmp_kind == cfg.echo_type);
  assign tex        = !echo && (icmp_kind == cfg.tex_type);

  always_comb begin
    byte_pos_next        = byte_pos;
    outer_hdr_bytes_next = outer_hdr_bytes;
    icmp_kind_next       = icmp_kind;
    src_addr_next        = src_addr;
    inner_hdr_bytes_next = inner_hdr_bytes;
    seen_id_next         = seen_id;
    seen_seq_next        = seen_seq;
    idseq                = {seen_id, seen_seq};
    if (take) begin
      byte_pos_next = byte_pos + 1'b1;
      if (byte_pos == '0) begin
        outer_hdr_bytes_next = {b[3:0], 2'b00};
      end
      if (pos >= CW'(12) && pos <= CW'(15)) begin
        src_addr_next = {src_addr[23:0], b};
      end
      if (byte_pos != '0) begin
        if (pos == hdr) begin
          icmp_kind_next = b;
        end else if (pos > hdr) begin
          if (echo) begin
            idseq = capture(pos, hdr, b, seen_id, seen_seq);
          end else if (tex) begin
            if (pos == hdr + CW'(ICMP_HDR_BYTES)) begin
              inner_hdr_bytes_next = {b[3:0], 2'b00};
            end else if (pos > hdr + CW'(ICMP_HDR_BYTES)) begin
              idseq = capture(pos, inner_base, b, seen_id, seen_seq);
            end
          end
        end
      end
      seen_id_next  = idseq[31:16];
      seen_seq_next = idseq[15:0];
    end
  end

  assign len     = {1'b0, byte_pos_next};
  assign hdr_n   = CW'(outer_hdr_bytes_next);
  assign inner_n = CW'(inner_hdr_bytes_next);
  assign echo_n  = (icmp_kind_next == cfg.echo_type);
  assign tex_n   = !echo_n && (icmp_kind_next == cfg.tex_type);

  always_comb begin
    if (hdr_n < CW'(HDR_MIN_BYTES)) begin
      st = ST_BADHDR;
    end else if (len < hdr_n + CW'(ICMP_HDR_BYTES)) begin
      st = ST_SHORT;
    end else if (!echo_n && !tex_n) begin
      st = ST_OTHER;
    end else if (tex_n && len < hdr_n + CW'(ICMP_HDR_BYTES + 1)) begin
      st = ST_SHORT;
    end else if (tex_n && inner_n < CW'(HDR_MIN_BYTES)) begin
      st = ST_BADHDR;
    end else if (tex_n && len < hdr_n + CW'(2 * ICMP_HDR_BYTES) + inner_n) begin
      st = ST_SHORT;
    end else if (seen_id_next != cfg.expected_id || seen_seq_next != want_seq) begin
      st = ST_MISMATCH;
    end else if (echo_n) begin
      st = ST_ECHO;
    end else begin
      st = ST_TEX;
    end
  end

  assign hit = (st == ST_ECHO) || (st == ST_TEX);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos        <= '0;
      outer_hdr_bytes <= '0;
      icmp_kind       <= '0;
      src_addr        <= '0;
      inner_hdr_bytes <= '0;
      seen_id         <= '0;
      seen_seq        <= '0;
      want_seq        <= '0;
      elapsed_ms      <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (do_report) begin
        byte_pos        <= '0;
        outer_hdr_bytes <= '0;
        icmp_kind       <= '0;
        src_addr        <= '0;
        inner_hdr_bytes <= '0;
        seen_id         <= '0;
        seen_seq        <= '0;
      end else begin
        byte_pos        <= byte_pos_next;
        outer_hdr_bytes <= outer_hdr_bytes_next;
        icmp_kind       <= icmp_kind_next;
        src_addr        <= src_addr_next;
        inner_hdr_bytes <= inner_hdr_bytes_next;
        seen_id         <= seen_id_next;
        seen_seq        <= seen_seq_next;
      end
      if (pop && head_cmd.kind == OP_ARM) begin
        want_seq   <= head_cmd.seq;
        elapsed_ms <= '0;
      end else if (pop && head_cmd.kind == OP_TICK && elapsed_ms != 16'hFFFF) begin
        elapsed_ms <= elapsed_ms + 1'b1;
      end
      if (do_report) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_report) begin
      status         <= st;
      matched        <= hit;
      source_ip      <= hit ? src_addr_next : 32'd0;
      rtt_ms         <= hit ? elapsed_ms : 16'd0;
      reached_target <= hit && (src_addr_next == cfg.target_ip);
    end
  end

endmodule

`default_nettype wire

[rtl/core/imr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module imr_checker
  import imr_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  status,
  input wire logic        matched,
  input wire logic [31:0] source_ip,
  input wire logic [15:0] rtt_ms,
  input wire logic        reached_target
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(source_ip)
      && $stable(rtt_ms))
    else $error("stalled result changed");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_BADHDR)
    else $error("status out of range");

  a_matched: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> matched == (status == ST_ECHO || status == ST_TEX))
    else $error("matched disagrees with status");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !matched |-> source_ip == 32'd0 && rtt_ms == 16'd0 && !reached_target)
    else $error("unmatched result carries data");

endmodule

bind icmp_response_matcher_core imr_checker u_imr_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .status         (status),
  .matched        (matched),
  .source_ip      (source_ip),
  .rtt_ms         (rtt_ms),
  .reached_target (reached_target)
);

`default_nettype wire
